@@ hw/rtl/mog_pkg.sv @@
package mog_pkg;

    localparam int REG_ADDR_W  = 6;
    localparam int REG_DATA_W  = 64;
    localparam int LANE_W      = 16;

    // register indexes, byte address is 8 * index
    localparam logic [2:0] REG_ENABLE_MASK   = 3'd0;
    localparam logic [2:0] REG_DEBOUNCE_MS   = 3'd1;
    localparam logic [2:0] REG_OBSERVE_LIMS  = 3'd2;
    localparam logic [2:0] REG_FAULT_LIMS    = 3'd3;
    localparam logic [2:0] REG_SOFT_LIMS     = 3'd4;
    localparam logic [2:0] REG_SOFT_ACTIVE   = 3'd5;

    localparam logic [15:0] PERMILLE_MAX = 16'd1000;

    // floor(x / 10) for x below 4105 as (x * 6554) >> 16
    localparam logic [25:0] DIV10_RECIP = 26'd6554;
    localparam logic [12:0] DEB_ROUND   = 13'd9;

    localparam int         DIV_STEPS = 16;
    localparam logic [3:0] DIV_LAST  = 4'(DIV_STEPS - 1);

    typedef struct packed {
        logic [3:0]  enable_mask;
        logic [11:0] debounce_ms;
        logic [63:0] observe_limits;
        logic [63:0] fault_limits;
        logic [63:0] soft_limits;
        logic        soft_active;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_WB
    } t_state;

    typedef struct packed {
        logic capture;
        logic eval;
        logic div_step;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } t_dp_sts;

    // ceil(ms / 10), at least one, saturated at 255
    function automatic logic [7:0] deb_ticks(input logic [11:0] ms);
        logic [12:0] x;
        logic [25:0] p;
        logic [9:0]  q;
        logic [7:0]  r;
        x = 13'(ms) + DEB_ROUND;
        p = 26'(x) * DIV10_RECIP;
        q = p[25:16];
        if (q == 10'd0) begin
            r = 8'd1;
        end else if (q > 10'd255) begin
            r = 8'd255;
        end else begin
            r = q[7:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/mog_regs.sv @@
module mog_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mog_pkg::REG_ADDR_W-1:0]      paddr,
    input  logic [mog_pkg::REG_DATA_W-1:0]      pwdata,
    output logic [mog_pkg::REG_DATA_W-1:0]      prdata,
    output logic                                pready,
    output mog_pkg::t_cfg                       o_cfg
);
    import mog_pkg::*;

    logic [3:0]  r_enable_mask;
    logic [11:0] r_debounce_ms;
    logic [63:0] r_observe_limits;
    logic [63:0] r_fault_limits;
    logic [63:0] r_soft_limits;
    logic        r_soft_active;
    logic        w_wr;
    logic [2:0]  w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_mask    <= 4'hF;
            r_debounce_ms    <= 12'd0;
            r_observe_limits <= '1;
            r_fault_limits   <= '1;
            r_soft_limits    <= '0;
            r_soft_active    <= 1'b0;
        end else if (w_wr) begin
            case (w_idx)
                REG_ENABLE_MASK:  r_enable_mask    <= pwdata[3:0];
                REG_DEBOUNCE_MS:  r_debounce_ms    <= pwdata[11:0];
                REG_OBSERVE_LIMS: r_observe_limits <= pwdata;
                REG_FAULT_LIMS:   r_fault_limits   <= pwdata;
                REG_SOFT_LIMS:    r_soft_limits    <= pwdata;
                REG_SOFT_ACTIVE:  r_soft_active    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ENABLE_MASK:  prdata = {60'd0, r_enable_mask};
            REG_DEBOUNCE_MS:  prdata = {52'd0, r_debounce_ms};
            REG_OBSERVE_LIMS: prdata = r_observe_limits;
            REG_FAULT_LIMS:   prdata = r_fault_limits;
            REG_SOFT_LIMS:    prdata = r_soft_limits;
            REG_SOFT_ACTIVE:  prdata = {63'd0, r_soft_active};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.enable_mask    = r_enable_mask;
    assign o_cfg.debounce_ms    = r_debounce_ms;
    assign o_cfg.observe_limits = r_observe_limits;
    assign o_cfg.fault_limits   = r_fault_limits;
    assign o_cfg.soft_limits    = r_soft_limits;
    assign o_cfg.soft_active    = r_soft_active;

endmodule

@@ hw/rtl/mog_ctrl.sv @@
module mog_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mog_pkg::t_dp_sts  i_sts,
    output mog_pkg::t_dp_cmd  o_cmd
);
    import mog_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.need_div ? ST_DIV : ST_WB;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                // hold until the output register is free
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

@@ hw/rtl/mog_dp.sv @@
module mog_dp #(
    parameter int MOTORS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mog_pkg::t_cfg     i_cfg,
    input  mog_pkg::t_dp_cmd  i_cmd,
    output mog_pkg::t_dp_sts  o_sts,
    input  logic [1:0]        i_motor_index,
    input  logic [15:0]       i_requested_permille,
    input  logic [15:0]       i_current_ma,
    input  logic              i_measurement_valid,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [15:0]       o_drive_permille,
    output logic              o_limited,
    output logic              o_observe_over,
    output logic              o_soft_would_apply,
    output logic              o_fault_trip,
    output logic              o_ctrl_valid,
    output logic [31:0]       o_observe_count,
    output logic [31:0]       o_fault_count
);
    import mog_pkg::*;

    localparam int IW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    // captured item
    logic [1:0]  r_m;
    logic [15:0] r_req;
    logic [15:0] r_cur;
    logic        r_meas;

    // per-motor state
    logic [7:0]  r_deb  [MOTORS];
    logic [31:0] r_ocnt [MOTORS];
    logic [31:0] r_fcnt [MOTORS];

    // staged result
    logic [15:0] r_res_applied;
    logic        r_res_lim;
    logic        r_res_obs;
    logic        r_res_softw;
    logic        r_res_fault;
    logic        r_res_cv;
    logic        r_res_neg;
    logic [31:0] r_res_ocnt;
    logic [31:0] r_res_fcnt;

    // divider
    logic [15:0] r_rem;
    logic [15:0] r_quo;
    logic [3:0]  r_div_cnt;

    // output register
    logic        r_out_valid;
    logic [15:0] r_applied;
    logic        r_limited;
    logic        r_obs;
    logic        r_softw;
    logic        r_fault;
    logic        r_cv;
    logic [31:0] r_ocnt_out;
    logic [31:0] r_fcnt_out;

    logic [IW-1:0] w_idx;
    logic          w_in_range;
    logic          w_enabled;
    logic          w_cv;
    logic [15:0]   w_obs_lim;
    logic [15:0]   w_fault_lim;
    logic [15:0]   w_soft;
    logic [7:0]    w_dcount;
    logic [7:0]    w_deb_cur;
    logic [7:0]    w_deb_next;
    logic          w_over_obs;
    logic          w_over_fault;
    logic          w_softw;
    logic          w_fault;
    logic          w_obs_inc;
    logic          w_fault_inc;
    logic [31:0]   w_ocnt_next;
    logic [31:0]   w_fcnt_next;
    logic          w_need_div;
    logic [15:0]   w_mag;
    logic [31:0]   w_prod;
    logic [16:0]   w_trial;
    logic          w_q_bit;
    logic [15:0]   w_q_clamp;
    logic [15:0]   w_scaled;

    assign w_idx       = r_m[IW-1:0];
    assign w_in_range  = {1'b0, r_m} < 3'(MOTORS);
    assign w_enabled   = i_cfg.enable_mask[r_m];
    assign w_cv        = w_in_range && w_enabled && r_meas;
    assign w_obs_lim   = i_cfg.observe_limits[LANE_W*r_m +: LANE_W];
    assign w_fault_lim = i_cfg.fault_limits[LANE_W*r_m +: LANE_W];
    assign w_soft      = i_cfg.soft_limits[LANE_W*r_m +: LANE_W];
    assign w_dcount    = deb_ticks(i_cfg.debounce_ms);
    assign w_deb_cur   = w_in_range ? r_deb[w_idx] : 8'd0;

    assign w_over_obs   = r_cur > w_obs_lim;
    assign w_over_fault = r_cur > w_fault_lim;
    assign w_softw      = (w_soft != 16'd0) && (r_cur > w_soft) && (r_req != 16'd0);

    always_comb begin
        if (!w_over_fault) begin
            w_deb_next = 8'd0;
        end else if (w_deb_cur < w_dcount) begin
            w_deb_next = w_deb_cur + 8'd1;
        end else begin
            w_deb_next = w_deb_cur;
        end
    end

    assign w_fault     = w_over_fault && (w_deb_next >= w_dcount);
    assign w_obs_inc   = w_cv && w_over_obs;
    assign w_fault_inc = w_cv && w_fault;
    assign w_ocnt_next = w_in_range ? r_ocnt[w_idx] + 32'(w_obs_inc) : 32'd0;
    assign w_fcnt_next = w_in_range ? r_fcnt[w_idx] + 32'(w_fault_inc) : 32'd0;
    assign w_need_div  = w_cv && i_cfg.soft_active && w_softw;

    assign w_mag  = r_req[15] ? 16'(~r_req + 16'd1) : r_req;
    assign w_prod = 32'(w_mag) * 32'(w_soft);

    // one restoring step; remainder stays below the current
    assign w_trial = {r_rem, r_quo[15]};
    assign w_q_bit = w_trial >= {1'b0, r_cur};

    assign w_q_clamp = (r_quo > PERMILLE_MAX) ? PERMILLE_MAX : r_quo;
    assign w_scaled  = r_res_neg ? 16'(~w_q_clamp + 16'd1) : w_q_clamp;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_m    <= i_motor_index;
            r_req  <= i_requested_permille;
            r_cur  <= i_current_ma;
            r_meas <= i_measurement_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MOTORS; i++) begin
                r_deb[i]  <= 8'd0;
                r_ocnt[i] <= 32'd0;
                r_fcnt[i] <= 32'd0;
            end
        end else if (i_cmd.eval && w_cv) begin
            r_deb[w_idx]  <= w_deb_next;
            r_ocnt[w_idx] <= w_ocnt_next;
            r_fcnt[w_idx] <= w_fcnt_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_res_applied <= (w_in_range && w_enabled) ? r_req : 16'd0;
            r_res_lim     <= w_need_div;
            r_res_obs     <= w_obs_inc;
            r_res_softw   <= w_cv && w_softw;
            r_res_fault   <= w_fault_inc;
            r_res_cv      <= w_cv;
            r_res_neg     <= r_req[15];
            r_res_ocnt    <= w_ocnt_next;
            r_res_fcnt    <= w_fcnt_next;
            // product is below current * 2^16, so its top half seeds the remainder
            r_rem         <= {1'b0, w_prod[30:16]};
            r_quo         <= w_prod[15:0];
            r_div_cnt     <= 4'd0;
        end else if (i_cmd.div_step) begin
            r_rem     <= w_q_bit ? 16'(w_trial - {1'b0, r_cur}) : w_trial[15:0];
            r_quo     <= {r_quo[14:0], w_q_bit};
            r_div_cnt <= r_div_cnt + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_applied  <= r_res_lim ? w_scaled : r_res_applied;
            r_limited  <= r_res_lim;
            r_obs      <= r_res_obs;
            r_softw    <= r_res_softw;
            r_fault    <= r_res_fault;
            r_cv       <= r_res_cv;
            r_ocnt_out <= r_res_ocnt;
            r_fcnt_out <= r_res_fcnt;
        end
    end

    assign o_sts.need_div = w_need_div;
    assign o_sts.div_last = r_div_cnt == DIV_LAST;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid        = r_out_valid;
    assign o_drive_permille   = r_applied;
    assign o_limited          = r_limited;
    assign o_observe_over     = r_obs;
    assign o_soft_would_apply = r_softw;
    assign o_fault_trip       = r_fault;
    assign o_ctrl_valid       = r_cv;
    assign o_observe_count    = r_ocnt_out;
    assign o_fault_count      = r_fcnt_out;

endmodule

@@ hw/rtl/motor_overcurrent_guard.sv @@
// Sequence: capture in idle, evaluate, divide (only when the soft limit scales), write-back.
// One item at a time: a new input is taken only once the last result is written back;
// the 16-step restoring divider (one quotient bit a cycle) runs only for scaled items.
// A stalled output register holds the next result in its write-back state.
// Reset (synchronous, active low) clears the sequencer, output valid, per-motor
// debounce and event counters, and loads the register defaults.
module motor_overcurrent_guard #(
    parameter int MOTORS = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mog_pkg::REG_ADDR_W-1:0]  paddr,
    input  logic [mog_pkg::REG_DATA_W-1:0]  pwdata,
    output logic [mog_pkg::REG_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_motor_index,
    input  logic signed [15:0]              i_requested_permille,
    input  logic [15:0]                     i_current_ma,
    input  logic                            i_measurement_valid,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [15:0]              o_drive_permille,
    output logic                            o_limited,
    output logic                            o_observe_over,
    output logic                            o_soft_would_apply,
    output logic                            o_fault_trip,
    output logic                            o_ctrl_valid,
    output logic [31:0]                     o_observe_count,
    output logic [31:0]                     o_fault_count
);
    import mog_pkg::*;

    t_cfg        w_cfg;
    t_dp_cmd     w_cmd;
    t_dp_sts     w_sts;
    logic [15:0] w_applied;

    mog_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mog_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mog_dp #(
        .MOTORS (MOTORS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (w_cfg),
        .i_cmd                (w_cmd),
        .o_sts                (w_sts),
        .i_motor_index        (i_motor_index),
        .i_requested_permille (i_requested_permille),
        .i_current_ma         (i_current_ma),
        .i_measurement_valid  (i_measurement_valid),
        .i_out_ready          (i_out_ready),
        .o_out_valid          (o_out_valid),
        .o_drive_permille     (w_applied),
        .o_limited            (o_limited),
        .o_observe_over       (o_observe_over),
        .o_soft_would_apply   (o_soft_would_apply),
        .o_fault_trip         (o_fault_trip),
        .o_ctrl_valid         (o_ctrl_valid),
        .o_observe_count      (o_observe_count),
        .o_fault_count        (o_fault_count)
    );

    assign o_drive_permille = $signed(w_applied);

`ifndef SYNTH
    // one item at a time: no transfer in the cycle after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in flight");

    // flags only on a controlled measurement
    a_flags_need_cv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ctrl_valid) |->
        (!o_limited && !o_observe_over && !o_soft_would_apply && !o_fault_trip))
        else $error("flag set without a valid controlled measurement");

    // scaled drive stays within the permille clamp
    a_scaled_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_limited) |->
        (o_drive_permille <= 16'sd1000 && o_drive_permille >= -16'sd1000))
        else $error("scaled drive outside clamp");

    // a scaled result needs the soft limit condition
    a_lim_needs_soft: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_limited) |-> o_soft_would_apply)
        else $error("scaling without soft limit condition");
`endif

endmodule
